/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, disabled while rst_ni is low.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/ipv4fh_pkg.sv */
package ipv4fh_pkg;

  localparam logic [15:0] HdrBytes   = 16'd20;
  localparam logic [15:0] MtuReset   = 16'd1500;
  localparam logic [15:0] MtuFloor   = 16'd1044;
  localparam logic [15:0] VerIhlWord = 16'h4500;
  localparam logic [15:0] MfBit      = 16'h2000;
  localparam logic [15:0] WordMask   = 16'hffff;

  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 80;

  // Packet header fields held for the whole packet
  typedef struct packed {
    logic [7:0]  tos;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_t;

  // One fragment as issued by the sequencer
  typedef struct packed {
    hdr_t        hdr;
    logic        mf;
    logic [12:0] off;
    logic [15:0] start;
    logic [15:0] nbytes;
  } frag_t;

  // One finished fragment header
  typedef struct packed {
    logic        mf;
    logic [12:0] off;
    logic [15:0] tot;
    logic [15:0] csum;
    logic [15:0] start;
    logic [15:0] nbytes;
  } res_t;

endpackage

/* rtl/ipv4fh_seq.sv */
module ipv4fh_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  input  logic [ipv4fh_pkg::InDataW-1:0]   in_data_i,
  output logic                             in_ready_o,
  input  logic                             adv_i,
  output logic                             frag_valid_o,
  output ipv4fh_pkg::frag_t                frag_o
);

  logic [15:0]       mtu_q;
  logic              busy_q;
  logic [15:0]       plen_q;
  logic [15:0]       sent_q;
  logic [15:0]       window_q;
  ipv4fh_pkg::hdr_t  hdr_q;
  logic              fvld_q;
  ipv4fh_pkg::frag_t frag_q;

  logic [15:0] mtu_eff;
  logic [15:0] win_raw;
  logic [15:0] remain;
  logic        mf;
  logic [15:0] nbytes;
  logic        accept;
  logic        issue;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign issue      = busy_q && adv_i;

  always_comb begin
    mtu_eff = (mtu_q < ipv4fh_pkg::MtuFloor) ? ipv4fh_pkg::MtuFloor : mtu_q;
    win_raw = mtu_eff - ipv4fh_pkg::HdrBytes;
    remain  = plen_q - sent_q;
    mf      = remain > window_q;
    nbytes  = mf ? window_q : remain;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q  <= ipv4fh_pkg::MtuReset;
      busy_q <= 1'b0;
      fvld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mtu_q <= cfg_data_i;
      end
      if (accept) begin
        busy_q <= (in_data_i[119:104] != 16'd0);
      end else if (issue && !mf) begin
        busy_q <= 1'b0;
      end
      if (adv_i) begin
        fvld_q <= busy_q;
      end
    end
  end

  // Packet context and fragment payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q.tos   <= in_data_i[7:0];
      hdr_q.ident <= in_data_i[23:8];
      hdr_q.ttl   <= in_data_i[31:24];
      hdr_q.proto <= in_data_i[39:32];
      hdr_q.src   <= in_data_i[71:40];
      hdr_q.dst   <= in_data_i[103:72];
      plen_q      <= in_data_i[119:104];
      sent_q      <= 16'd0;
      window_q    <= {win_raw[15:3], 3'b000};
    end else if (issue) begin
      sent_q <= sent_q + nbytes;
    end
    if (adv_i) begin
      frag_q.hdr    <= hdr_q;
      frag_q.mf     <= mf;
      frag_q.off    <= sent_q[15:3];
      frag_q.start  <= sent_q;
      frag_q.nbytes <= nbytes;
    end
  end

  assign frag_valid_o = fvld_q;
  assign frag_o       = frag_q;

endmodule

/* rtl/ipv4fh_csum.sv */
module ipv4fh_csum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              frag_valid_i,
  input  ipv4fh_pkg::frag_t frag_i,
  output logic              res_valid_o,
  output ipv4fh_pkg::res_t  res_o
);

  // Stage 2: two partial sums
  logic             v2_q;
  logic [17:0]      suma_q;
  logic [18:0]      sumb_q;
  ipv4fh_pkg::res_t r2_q;
  // Stage 3: full sum
  logic             v3_q;
  logic [19:0]      sum_q;
  ipv4fh_pkg::res_t r3_q;
  // Stage 4: folded and complemented
  logic             v4_q;
  ipv4fh_pkg::res_t r4_q;

  logic [15:0]      tot;
  logic [15:0]      fragw;
  logic [17:0]      suma_d;
  logic [18:0]      sumb_d;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  ipv4fh_pkg::res_t r4_d;

  always_comb begin
    tot    = ipv4fh_pkg::HdrBytes + frag_i.nbytes;
    fragw  = (frag_i.mf ? ipv4fh_pkg::MfBit : 16'd0) | {3'b000, frag_i.off};
    suma_d = 18'({8'h00, ipv4fh_pkg::VerIhlWord[15:8], frag_i.hdr.tos})
           + 18'(frag_i.hdr.ident)
           + 18'({frag_i.hdr.ttl, frag_i.hdr.proto})
           + 18'(frag_i.hdr.src[31:16]);
    sumb_d = 19'(frag_i.hdr.src[15:0])
           + 19'(frag_i.hdr.dst[31:16])
           + 19'(frag_i.hdr.dst[15:0])
           + 19'(tot)
           + 19'(fragw);
    // end-around carry, twice is enough for a 20-bit sum
    fold1  = 17'(sum_q[15:0]) + 17'(sum_q[19:16]);
    fold2  = fold1[15:0] + 16'(fold1[16]);
    r4_d      = r3_q;
    r4_d.csum = ~fold2 & ipv4fh_pkg::WordMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= frag_valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      suma_q      <= suma_d;
      sumb_q      <= sumb_d;
      r2_q.mf     <= frag_i.mf;
      r2_q.off    <= frag_i.off;
      r2_q.tot    <= tot;
      r2_q.csum   <= 16'd0;
      r2_q.start  <= frag_i.start;
      r2_q.nbytes <= frag_i.nbytes;

      sum_q <= 20'(suma_q) + 20'(sumb_q);
      r3_q  <= r2_q;

      r4_q <= r4_d;
    end
  end

  assign res_valid_o = v4_q;
  assign res_o       = r4_q;

endmodule

/* rtl/ipv4_fragment_header_generator.sv */
// Channel  | Dir | Signals                      | Content
// ---------+-----+------------------------------+--------------------------------------
// s_axis   | in  | tvalid tready tdata[119:0]   | packet request
// m_axis   | out | tvalid tready tdata[79:0]    | fragment header, tuser = MF, tlast
// cfg      | in  | cfg_valid cfg_ready cfg_data[15:0] | mtu_bytes write
//
// A packet request is taken while no packet is being split; each fragment
// then leaves the sequencer one per cycle unless m_axis stalls; a packet has
// at most 64 fragments. Each result passes the sequencer output register and
// the checksum stages. rst_ni clears all valid bits and sets mtu_bytes to
// 1500. A stall on m_axis freezes every stage at once; a zero payload is
// accepted and yields no result.
`include "assert_macros.svh"

module ipv4_fragment_header_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  // tos[7:0] ident[23:8] ttl[31:24] proto[39:32] src[71:40] dst[103:72]
  // payload_len[119:104]
  input  logic [119:0]  s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // frag_offset[12:0] tot_length[28:13] hdr_checksum[44:29]
  // payload_start[60:45] payload_bytes[76:61] zero[79:77]
  output logic [79:0]   m_axis_tdata,
  output logic [0:0]    m_axis_tuser,   // more_fragments[0]
  output logic          m_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  logic              adv;
  logic              frag_valid;
  ipv4fh_pkg::frag_t frag;
  logic              res_valid;
  ipv4fh_pkg::res_t  res;

  // Advance the whole pipeline unless a result waits on a stalled sink
  assign adv       = !res_valid || m_axis_tready;
  assign cfg_ready = 1'b1;

  ipv4fh_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (s_axis_tvalid),
    .in_data_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .adv_i        (adv),
    .frag_valid_o (frag_valid),
    .frag_o       (frag)
  );

  ipv4fh_csum u_csum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .frag_valid_i (frag_valid),
    .frag_i       (frag),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {3'b000, res.nbytes, res.start, res.csum, res.tot, res.off};
  assign m_axis_tuser  = res.mf;
  assign m_axis_tlast  = !res.mf;

  // Total length must match the slice carried through the pipeline
  `ASSERT_RST(a_tot_len, res_valid |-> (res.tot == res.nbytes + ipv4fh_pkg::HdrBytes), "bad length")
  // Every fragment but the final one carries a multiple of 8 bytes
  `ASSERT_RST(a_mf_align, (res_valid && res.mf) |-> (res.nbytes[2:0] == 3'b000), "unaligned MF slice")
  // Offset and slice start describe the same position
  `ASSERT_RST(a_off_start, res_valid |-> (res.off == res.start[15:3] && res.start[2:0] == 3'b000), "offset mismatch")

endmodule

/* tb/tb_ipv4_fragment_header_generator.sv */
`timescale 1ns / 100ps

module tb_ipv4_fragment_header_generator;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MaxFrags      = 64;
  localparam int unsigned IdlePct       = 35;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseItems    = 46;

  // One packet request as the sender sees it
  typedef struct {
    logic [7:0]  tos;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] plen;
  } pkt_t;

  // One fragment header as it should leave the block
  typedef struct {
    logic        mf;
    logic [12:0] off;
    logic [15:0] tot;
    logic [15:0] csum;
    logic [15:0] start;
    logic [15:0] nbytes;
    logic        last;
  } frag_hdr_t;

  // Predicts the fragment headers of each accepted request and checks the
  // headers that come out against them, oldest first.
  class frag_scoreboard;
    logic [15:0] mtu;
    frag_hdr_t   frag_q[$];
    int unsigned errors;

    function new();
      mtu    = ipv4fh_pkg::MtuReset;
      errors = 0;
    endfunction

    function void set_mtu(logic [15:0] value);
      mtu = value;
    endfunction

    // Payload bytes per full fragment: clamp the MTU, drop the header, round to 8
    function int unsigned window();
      int unsigned eff;
      eff = (mtu < ipv4fh_pkg::MtuFloor) ? ipv4fh_pkg::MtuFloor : mtu;
      return (eff - ipv4fh_pkg::HdrBytes) & ~32'd7;
    endfunction

    function int unsigned pending();
      return frag_q.size();
    endfunction

    // Complemented ones complement sum of the ten header words, check field at zero
    function logic [15:0] header_checksum(pkt_t p, logic [15:0] tot, logic [15:0] flags_off);
      logic [31:0] acc;
      acc = {16'd0, ipv4fh_pkg::VerIhlWord | {8'd0, p.tos}};
      acc += tot;
      acc += p.ident;
      acc += flags_off;
      acc += {p.ttl, p.proto};
      acc += p.src[31:16];
      acc += p.src[15:0];
      acc += p.dst[31:16];
      acc += p.dst[15:0];
      while (acc > 32'hffff) acc = (acc >> 16) + (acc & 32'hffff);
      return ~acc[15:0];
    endfunction

    function void note_packet(pkt_t p);
      int unsigned win;
      int unsigned sent;
      int unsigned n;
      int unsigned k;
      frag_hdr_t   f;
      win  = window();
      sent = 0;
      k    = 0;
      while (sent < p.plen && k < MaxFrags) begin
        f.mf     = (p.plen - sent) > win;
        n        = f.mf ? win : p.plen - sent;
        f.off    = sent[15:3];
        f.tot    = ipv4fh_pkg::HdrBytes + n[15:0];
        f.csum   = header_checksum(p, f.tot,
                                   (f.mf ? ipv4fh_pkg::MfBit : 16'd0) | {3'd0, f.off});
        f.start  = sent[15:0];
        f.nbytes = n[15:0];
        f.last   = !f.mf;
        frag_q.push_back(f);
        sent += n;
        k++;
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic mf, logic [79:0] data, logic last);
      frag_hdr_t f;
      if (frag_q.size() == 0) begin
        errors++;
        $display("%0t: fragment header with none pending: mf=%0b data=0x%h last=%0b",
                 $time, mf, data, last);
        return;
      end
      f = frag_q.pop_front();
      compare("more_fragments", 32'(f.mf), 32'(mf));
      compare("frag_offset", 32'(f.off), 32'(data[12:0]));
      compare("tot_length", 32'(f.tot), 32'(data[28:13]));
      compare("hdr_checksum", 32'(f.csum), 32'(data[44:29]));
      compare("payload_start", 32'(f.start), 32'(data[60:45]));
      compare("payload_bytes", 32'(f.nbytes), 32'(data[76:61]));
      compare("last", 32'(f.last), 32'(last));
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic [119:0]  s_axis_tdata = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [79:0]   m_axis_tdata;
  logic [0:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [15:0]   cfg_data = '0;

  frag_scoreboard sb = new();

  // Flow control knobs, written by the stimulus process only
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned hold_asked = 0;
  // Owned by the receiver process, but cycle_count by the watchdog
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  ipv4_fragment_header_generator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d headers pending",
               $time, cycle_count, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: drive tready at the falling edge. A hold-off request from the
  // stimulus holds tready low for a long stretch so the block backs up.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      m_axis_tready <= 1'b0;
      hold_left <= HoldOffCycles - 1;
      hold_taken <= hold_taken + 1;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IdlePct);
    end
  end

  // Sample accepted fragment headers at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser[0], m_axis_tdata, m_axis_tlast);
    end
  end

  function automatic pkt_t rand_packet(logic [15:0] plen);
    pkt_t p;
    p.tos   = 8'($urandom);
    p.ident = 16'($urandom);
    p.ttl   = 8'($urandom);
    p.proto = 8'($urandom);
    p.src   = $urandom;
    p.dst   = $urandom;
    p.plen  = plen;
    return p;
  endfunction

  // Lengths of zero, small, around whole windows (where the MF decision flips) or random
  function automatic logic [15:0] pick_payload(int unsigned win);
    int unsigned roll;
    int unsigned k;
    int          len;
    roll = $urandom_range(99);
    if (roll < 5) return 16'd0;
    if (roll < 30) return 16'($urandom_range(64, 1));
    if (roll < 60) begin
      k   = $urandom_range((65535 / win < 63) ? 65535 / win : 63, 1);
      len = int'(k * win) + int'($urandom_range(2, 0)) - 1;
      if (len > 65535) len = 65535;
      return len[15:0];
    end
    if (roll < 85) return 16'($urandom_range(4000, 1));
    return 16'($urandom_range(65535, 1));
  endfunction

  // Offer one request; random gap in front unless the sender is steady
  task automatic send_packet(input pkt_t p);
    if (!tx_steady && $urandom_range(99) < IdlePct) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < IdlePct) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.plen, p.dst, p.src, p.proto, p.ttl, p.ident, p.tos};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_packet(p);
  endtask

  // Drop valid, wait for every pending header, then let the block go idle
  task automatic settle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mtu(input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_mtu(value);
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  initial begin
    pkt_t        p;
    logic [15:0] mtu;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: reset MTU of 1500, window 1480
    send_packet(rand_packet(16'd0));         // zero payload, no header expected
    send_packet(rand_packet(16'd1));
    send_packet(rand_packet(16'd1480));      // exact fill of one window
    send_packet(rand_packet(16'd1481));
    send_packet(rand_packet(16'd2960));      // exact fill of the second window
    send_packet(rand_packet(16'd65535));     // payload beyond the nominal maximum
    p = '{tos: 8'hff, ident: 16'hffff, ttl: 8'hff, proto: 8'hff,
          src: 32'hffff_ffff, dst: 32'hffff_ffff, plen: 16'd65515};
    send_packet(p);                          // heavy carry folding in the checksum
    p = '{tos: 8'h00, ident: 16'h0000, ttl: 8'h00, proto: 8'h00,
          src: 32'h0, dst: 32'h0, plen: 16'd8};
    send_packet(p);
    settle();

    // MTU below the floor behaves as 1044, window 1024, up to 64 fragments
    write_mtu(16'd0);
    send_packet(rand_packet(16'd65535));
    send_packet(rand_packet(16'd1024));
    send_packet(rand_packet(16'd1025));
    settle();
    write_mtu(16'd1043);
    send_packet(rand_packet(16'd2048));
    send_packet(rand_packet(16'd1023));
    settle();

    // Largest MTU: window 65512
    write_mtu(16'hffff);
    send_packet(rand_packet(16'd65535));
    send_packet(rand_packet(16'd65512));
    send_packet(rand_packet(16'd65513));
    settle();

    // Window rounding down to a multiple of 8
    write_mtu(16'd1051);
    send_packet(rand_packet(16'd3072));
    send_packet(rand_packet(16'd3073));
    settle();

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: mtu = ipv4fh_pkg::MtuFloor;
        1: mtu = 16'hffff;
        3: mtu = ipv4fh_pkg::MtuReset;
        4: mtu = 16'($urandom_range(ipv4fh_pkg::MtuFloor - 1, 0));
        5: mtu = 16'($urandom_range(9000, ipv4fh_pkg::MtuFloor));
        6: mtu = ipv4fh_pkg::MtuFloor;
        default: mtu = 16'($urandom_range(65535, ipv4fh_pkg::MtuFloor));
      endcase
      write_mtu(mtu);
      // Phase 3 floods the block against a long receiver hold-off;
      // phase 5 runs both sides without idling.
      tx_steady = (ph == 3) || (ph == 5);
      rx_steady = (ph == 5);
      if (ph == 3) hold_asked++;
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        send_packet(rand_packet(pick_payload(sb.window())));
        if (i == PhaseItems / 2) settle();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ipv4fh_pkg.sv
rtl/ipv4fh_seq.sv
rtl/ipv4fh_csum.sv
rtl/ipv4_fragment_header_generator.sv
tb/tb_ipv4_fragment_header_generator.sv
